// File: sv/sbc_pkg.sv
// Shared types, constants and codes of the staged burner controller.
package sbc_pkg;

  // Field widths.
  localparam int TEMP_BITS    = 16;
  localparam int TIME_BITS    = 32;
  localparam int PERIOD_BITS  = 20;
  localparam int DUTY_BITS    = 7;
  localparam int OFFSET_BITS  = 16;
  localparam int HYST_BITS    = 15;
  localparam int MODE_BITS    = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = PERIOD_BITS;

  // Threshold compares run on a width that holds an offset plus the hysteresis.
  localparam int CMP_BITS  = ((TEMP_BITS > OFFSET_BITS) ? TEMP_BITS : OFFSET_BITS) + 2;
  // 100 * remainder and duty * period both fit in this width.
  localparam int PROD_BITS = PERIOD_BITS + DUTY_BITS;
  localparam int DIV_CNT_BITS = $clog2(TIME_BITS);

  localparam logic [PROD_BITS-1:0] PCT_FULL = PROD_BITS'(100);
  localparam logic signed [TEMP_BITS-1:0] PROBE_FAULT_ERR = TEMP_BITS'(-99 * 16);

  // Valve stage: bit 0 is the low valve closed, bit 1 the high valve closed.
  localparam logic [1:0] STAGE_HIGH   = 2'd0;
  localparam logic [1:0] STAGE_MEDIUM = 2'd1;
  localparam logic [1:0] STAGE_LOW    = 2'd2;
  localparam logic [1:0] STAGE_OFF    = 2'd3;

  // Burner status codes.
  localparam logic [1:0] STATUS_PILOT_LIT   = 2'd0;
  localparam logic [1:0] STATUS_FEEDBACK_FLT = 2'd1;
  localparam logic [1:0] STATUS_PILOT_OFF   = 2'd2;
  localparam logic [1:0] STATUS_PILOT_FLT   = 2'd3;

  // Drive modes; the two unused codes act as off.
  typedef enum logic [MODE_BITS-1:0] {
    MODE_OFF      = 3'd0,
    MODE_AUTO     = 3'd1,
    MODE_PWM_LOW  = 3'd2,
    MODE_PWM_MED  = 3'd3,
    MODE_PWM_HIGH = 3'd4,
    MODE_PWM_IDLE = 3'd5
  } drive_mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DRIVE_MODE    = 3'd0,
    REG_FAULT_INHIBIT = 3'd1,
    REG_PWM_PERIOD    = 3'd2,
    REG_PWM_DUTY      = 3'd3,
    REG_HIGH_OFFSET   = 3'd4,
    REG_MEDIUM_OFFSET = 3'd5,
    REG_LOW_OFFSET    = 3'd6,
    REG_HYSTERESIS    = 3'd7
  } reg_index_t;

  // Register file contents.
  typedef struct packed {
    logic [MODE_BITS-1:0]          drive_mode;
    logic                          fault_inhibit;
    logic [PERIOD_BITS-1:0]        pwm_period_ms;
    logic [DUTY_BITS-1:0]          pwm_duty_pct;
    logic signed [OFFSET_BITS-1:0] high_offset;
    logic signed [OFFSET_BITS-1:0] medium_offset;
    logic signed [OFFSET_BITS-1:0] low_offset;
    logic [HYST_BITS-1:0]          hysteresis;
  } cfg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_AUTO,
    ST_MOD,
    ST_MUL,
    ST_APPLY,
    ST_FINISH
  } state_t;

endpackage

// File: sv/sbc_ifs.sv
// Valid/ready channel interfaces for the tick, result and configuration ports.
interface sbc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sbc_pkg::TEMP_BITS-1:0]  feedback_temp;
  logic                                  probe_fault;
  logic                                  pilot_lit;
  logic signed [sbc_pkg::TEMP_BITS-1:0]  target_temp;
  logic [sbc_pkg::TIME_BITS-1:0]         now_ms;

  modport source (output valid, feedback_temp, probe_fault, pilot_lit, target_temp, now_ms,
                  input ready);
  modport sink (input valid, feedback_temp, probe_fault, pilot_lit, target_temp, now_ms,
                output ready);
endinterface

interface sbc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  valve_low_closed;
  logic                                  valve_high_closed;
  logic [1:0]                            burner_status;
  logic                                  faulted;
  logic signed [sbc_pkg::TEMP_BITS-1:0]  control_error;

  modport source (output valid, valve_low_closed, valve_high_closed, burner_status, faulted,
                  control_error, input ready);
  modport sink (input valid, valve_low_closed, valve_high_closed, burner_status, faulted,
                control_error, output ready);
endinterface

interface sbc_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [sbc_pkg::CFG_IDX_BITS-1:0]      index;
  logic [sbc_pkg::CFG_DATA_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/sbc_regs.sv
// Configuration register file of the staged burner controller.
module sbc_regs (
  input  logic               clk,
  input  logic               rst,
  sbc_cfg_if.sink            cfg,
  output sbc_pkg::cfg_t      regs
);

  sbc_pkg::cfg_t regs_q;

  // Writes are always taken.
  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  // One register per write, truncated to its width.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.drive_mode    <= sbc_pkg::MODE_BITS'(sbc_pkg::MODE_OFF);
      regs_q.fault_inhibit <= 1'b0;
      regs_q.pwm_period_ms <= sbc_pkg::PERIOD_BITS'(1000);
      regs_q.pwm_duty_pct  <= '0;
      regs_q.high_offset   <= sbc_pkg::OFFSET_BITS'(160);
      regs_q.medium_offset <= sbc_pkg::OFFSET_BITS'(80);
      regs_q.low_offset    <= '0;
      regs_q.hysteresis    <= sbc_pkg::HYST_BITS'(16);
    end else if (cfg.valid) begin
      unique case (sbc_pkg::reg_index_t'(cfg.index))
        sbc_pkg::REG_DRIVE_MODE:    regs_q.drive_mode    <= cfg.data[sbc_pkg::MODE_BITS-1:0];
        sbc_pkg::REG_FAULT_INHIBIT: regs_q.fault_inhibit <= cfg.data[0];
        sbc_pkg::REG_PWM_PERIOD:    regs_q.pwm_period_ms <= cfg.data[sbc_pkg::PERIOD_BITS-1:0];
        sbc_pkg::REG_PWM_DUTY:      regs_q.pwm_duty_pct  <= cfg.data[sbc_pkg::DUTY_BITS-1:0];
        sbc_pkg::REG_HIGH_OFFSET:   regs_q.high_offset   <= cfg.data[sbc_pkg::OFFSET_BITS-1:0];
        sbc_pkg::REG_MEDIUM_OFFSET: regs_q.medium_offset <= cfg.data[sbc_pkg::OFFSET_BITS-1:0];
        sbc_pkg::REG_LOW_OFFSET:    regs_q.low_offset    <= cfg.data[sbc_pkg::OFFSET_BITS-1:0];
        sbc_pkg::REG_HYSTERESIS:    regs_q.hysteresis    <= cfg.data[sbc_pkg::HYST_BITS-1:0];
      endcase
    end
  end

endmodule

// File: sv/sbc_divider.sv
// Bit-serial restoring modulo unit: remainder of the elapsed time over the PWM period.
module sbc_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [sbc_pkg::TIME_BITS-1:0]     dividend,
  input  logic [sbc_pkg::PERIOD_BITS-1:0]   divisor,
  output logic                              done,
  output logic [sbc_pkg::PERIOD_BITS-1:0]   remainder
);

  logic                                busy;
  logic [sbc_pkg::DIV_CNT_BITS-1:0]    cnt;
  logic [sbc_pkg::TIME_BITS-1:0]       shreg;
  logic [sbc_pkg::PERIOD_BITS-1:0]     dsr;
  logic [sbc_pkg::PERIOD_BITS-1:0]     rem;
  logic [sbc_pkg::PERIOD_BITS:0]       trial;
  logic [sbc_pkg::PERIOD_BITS:0]       diff;

  // One dividend bit enters the partial remainder per cycle.
  assign trial = {rem, shreg[sbc_pkg::TIME_BITS-1]};
  assign diff  = trial - {1'b0, dsr};
  assign remainder = rem;

  // Control: busy while bits remain, a one-cycle done after the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == sbc_pkg::DIV_CNT_BITS'(sbc_pkg::TIME_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the remainder stays below the divisor, so it fits the period width.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dsr   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[sbc_pkg::TIME_BITS-2:0], 1'b0};
      if (!diff[sbc_pkg::PERIOD_BITS]) begin
        rem <= diff[sbc_pkg::PERIOD_BITS-1:0];
      end else begin
        rem <= trial[sbc_pkg::PERIOD_BITS-1:0];
      end
    end
  end

endmodule

// File: sv/staged_burner_controller.sv
// Top level of the staged burner controller: tick sequencer, valve stage and result register.
//
// Usage: configuration writes arrive on cfg (index 0..7, always ready); the user
// must make them only while the block is idle, which the block does not enforce.
// Each control tick is an item on tick; one result item per tick leaves on result.
// Timing: tick.ready is high only while the sequencer is idle. In off mode an
// item passes the evaluate and finish states; auto mode adds the auto state.
// In the PWM modes the elapsed time is reduced modulo the period by a
// bit-serial unit, one time bit per cycle, in the modulo state, followed by the
// multiply, apply and finish states. The next tick is accepted the cycle after
// the result register is loaded; no new tick is taken while one is in work.
// Reset: synchronous; clears the registers to their defaults, the valve stage
// to both valves closed and ends any PWM session. No clearing pass is needed.
// Stall: the result stays in its register until taken; the next item may be
// accepted and worked on meanwhile, and waits in the last state until the
// register frees up.
module staged_burner_controller (
  input  logic          clk,
  input  logic          rst,
  sbc_cfg_if.sink       cfg,
  sbc_in_if.sink        tick,
  sbc_out_if.source     result
);

  sbc_pkg::cfg_t   regs;
  sbc_pkg::state_t state;
  sbc_pkg::state_t state_next;

  // Latched tick.
  logic signed [sbc_pkg::TEMP_BITS-1:0]  temp;
  logic signed [sbc_pkg::TEMP_BITS-1:0]  target;
  logic                                  probe_flt;
  logic                                  pilot;
  logic [sbc_pkg::TIME_BITS-1:0]         now;

  // Control state.
  logic [1:0]                            valve_stage;
  logic [sbc_pkg::TIME_BITS-1:0]         pwm_start_ms;
  logic                                  pwm_running;

  // Per-item results.
  logic signed [sbc_pkg::TEMP_BITS-1:0]  err;
  logic [1:0]                            status;
  logic                                  faulted;

  // Multiplier outputs.
  logic [sbc_pkg::PROD_BITS-1:0]         prod_into;
  logic [sbc_pkg::PROD_BITS-1:0]         prod_duty;

  // Result register.
  logic                                  out_valid;
  logic [1:0]                            out_stage;
  logic [1:0]                            out_status;
  logic                                  out_faulted;
  logic signed [sbc_pkg::TEMP_BITS-1:0]  out_err;

  // Sequencer outputs.
  logic in_ready;
  logic div_start;
  logic out_load;
  logic slot_free;

  // Divider.
  logic                                  div_done;
  logic [sbc_pkg::PERIOD_BITS-1:0]       div_rem;
  logic [sbc_pkg::PERIOD_BITS-1:0]       period_eff;
  logic [sbc_pkg::TIME_BITS-1:0]         elapsed;

  // Decoded mode and tick-level judgements.
  logic                                  mode_off;
  logic                                  mode_auto;
  logic signed [sbc_pkg::TEMP_BITS:0]    diff;
  logic signed [sbc_pkg::TEMP_BITS-1:0]  err_calc;
  logic [1:0]                            status_calc;
  logic                                  faulted_calc;
  logic [1:0]                            pwm_level;

  // Threshold operands.
  logic signed [sbc_pkg::CMP_BITS-1:0]   err_x;
  logic signed [sbc_pkg::CMP_BITS-1:0]   hi_x;
  logic signed [sbc_pkg::CMP_BITS-1:0]   med_x;
  logic signed [sbc_pkg::CMP_BITS-1:0]   lo_x;
  logic signed [sbc_pkg::CMP_BITS-1:0]   hy_x;
  logic [1:0]                            auto_stage;

  sbc_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  sbc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (elapsed),
    .divisor   (period_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Mode decode; the unused codes count as off.
  always_comb begin
    mode_auto = (regs.drive_mode == sbc_pkg::MODE_BITS'(sbc_pkg::MODE_AUTO));
    mode_off  = (regs.drive_mode == sbc_pkg::MODE_BITS'(sbc_pkg::MODE_OFF)) ||
                (regs.drive_mode > sbc_pkg::MODE_BITS'(sbc_pkg::MODE_PWM_IDLE));
  end

  // Saturated control error, status and fault judgement.
  always_comb begin
    diff = {target[sbc_pkg::TEMP_BITS-1], target} - {temp[sbc_pkg::TEMP_BITS-1], temp};
    if (diff[sbc_pkg::TEMP_BITS] != diff[sbc_pkg::TEMP_BITS-1]) begin
      err_calc = {diff[sbc_pkg::TEMP_BITS], {(sbc_pkg::TEMP_BITS-1){~diff[sbc_pkg::TEMP_BITS]}}};
    end else begin
      err_calc = diff[sbc_pkg::TEMP_BITS-1:0];
    end
    if (probe_flt) begin
      err_calc = sbc_pkg::PROBE_FAULT_ERR;
    end

    status_calc  = probe_flt ? sbc_pkg::STATUS_FEEDBACK_FLT : sbc_pkg::STATUS_PILOT_LIT;
    faulted_calc = probe_flt && mode_auto;
    if (mode_off) begin
      status_calc = pilot ? sbc_pkg::STATUS_PILOT_LIT : sbc_pkg::STATUS_PILOT_OFF;
    end else if (!pilot) begin
      status_calc = sbc_pkg::STATUS_PILOT_FLT;
      if (!regs.fault_inhibit) begin
        faulted_calc = 1'b1;
      end
    end
  end

  // PWM operands: zero period acts as one; a fresh session starts at zero elapsed.
  always_comb begin
    period_eff = (regs.pwm_period_ms == '0) ? sbc_pkg::PERIOD_BITS'(1) : regs.pwm_period_ms;
    elapsed    = pwm_running ? (now - pwm_start_ms) : '0;
  end

  // Stage a PWM mode applies during the on share.
  always_comb begin
    unique case (regs.drive_mode)
      sbc_pkg::MODE_BITS'(sbc_pkg::MODE_PWM_LOW):  pwm_level = sbc_pkg::STAGE_LOW;
      sbc_pkg::MODE_BITS'(sbc_pkg::MODE_PWM_MED):  pwm_level = sbc_pkg::STAGE_MEDIUM;
      sbc_pkg::MODE_BITS'(sbc_pkg::MODE_PWM_HIGH): pwm_level = sbc_pkg::STAGE_HIGH;
      default:                                     pwm_level = sbc_pkg::STAGE_OFF;
    endcase
  end

  // Four-stage thermostat: step down at the offset, step up at offset plus hysteresis.
  always_comb begin
    err_x = {{(sbc_pkg::CMP_BITS-sbc_pkg::TEMP_BITS){err[sbc_pkg::TEMP_BITS-1]}}, err};
    hi_x  = {{(sbc_pkg::CMP_BITS-sbc_pkg::OFFSET_BITS){regs.high_offset[sbc_pkg::OFFSET_BITS-1]}},
             regs.high_offset};
    med_x = {{(sbc_pkg::CMP_BITS-sbc_pkg::OFFSET_BITS){regs.medium_offset[sbc_pkg::OFFSET_BITS-1]}},
             regs.medium_offset};
    lo_x  = {{(sbc_pkg::CMP_BITS-sbc_pkg::OFFSET_BITS){regs.low_offset[sbc_pkg::OFFSET_BITS-1]}},
             regs.low_offset};
    hy_x  = {{(sbc_pkg::CMP_BITS-sbc_pkg::HYST_BITS){1'b0}}, regs.hysteresis};
    auto_stage = valve_stage;
    unique case (valve_stage)
      sbc_pkg::STAGE_HIGH: begin
        if (!(err_x > hi_x)) auto_stage = sbc_pkg::STAGE_MEDIUM;
      end
      sbc_pkg::STAGE_MEDIUM: begin
        if (err_x > hi_x + hy_x) auto_stage = sbc_pkg::STAGE_HIGH;
        else if (!(err_x > med_x)) auto_stage = sbc_pkg::STAGE_LOW;
      end
      sbc_pkg::STAGE_LOW: begin
        if (err_x > med_x + hy_x) auto_stage = sbc_pkg::STAGE_MEDIUM;
        else if (!(err_x > lo_x)) auto_stage = sbc_pkg::STAGE_OFF;
      end
      sbc_pkg::STAGE_OFF: begin
        if (err_x > lo_x + hy_x) auto_stage = sbc_pkg::STAGE_LOW;
      end
    endcase
  end

  // Result register is free when empty or being taken this cycle.
  assign slot_free = !out_valid || result.ready;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sbc_pkg::ST_IDLE: begin
        if (tick.valid) state_next = sbc_pkg::ST_EVAL;
      end
      sbc_pkg::ST_EVAL: begin
        if (mode_off) begin
          state_next = sbc_pkg::ST_FINISH;
        end else if (mode_auto) begin
          state_next = sbc_pkg::ST_AUTO;
        end else begin
          state_next = sbc_pkg::ST_MOD;
        end
      end
      sbc_pkg::ST_AUTO:  state_next = sbc_pkg::ST_FINISH;
      sbc_pkg::ST_MOD: begin
        if (div_done) state_next = sbc_pkg::ST_MUL;
      end
      sbc_pkg::ST_MUL:   state_next = sbc_pkg::ST_APPLY;
      sbc_pkg::ST_APPLY: state_next = sbc_pkg::ST_FINISH;
      sbc_pkg::ST_FINISH: begin
        if (slot_free) state_next = sbc_pkg::ST_IDLE;
      end
      default: state_next = sbc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = (state == sbc_pkg::ST_IDLE);
    div_start = (state == sbc_pkg::ST_EVAL) && !mode_off && !mode_auto;
    out_load  = (state == sbc_pkg::ST_FINISH) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Tick capture.
  always_ff @(posedge clk) begin
    if (in_ready && tick.valid) begin
      temp      <= tick.feedback_temp;
      target    <= tick.target_temp;
      probe_flt <= tick.probe_fault;
      pilot     <= tick.pilot_lit;
      now       <= tick.now_ms;
    end
  end

  // Per-item judgement and PWM compare operands.
  always_ff @(posedge clk) begin
    if (state == sbc_pkg::ST_EVAL) begin
      err     <= err_calc;
      status  <= status_calc;
      faulted <= faulted_calc;
    end
    if (state == sbc_pkg::ST_MUL) begin
      prod_into <= sbc_pkg::PROD_BITS'(div_rem) * sbc_pkg::PCT_FULL;
      prod_duty <= sbc_pkg::PROD_BITS'(regs.pwm_duty_pct) * sbc_pkg::PROD_BITS'(period_eff);
    end
  end

  // Valve stage and PWM session.
  always_ff @(posedge clk) begin
    if (rst) begin
      valve_stage  <= sbc_pkg::STAGE_OFF;
      pwm_start_ms <= '0;
      pwm_running  <= 1'b0;
    end else begin
      unique case (state)
        sbc_pkg::ST_EVAL: begin
          if (mode_off) begin
            valve_stage <= sbc_pkg::STAGE_OFF;
          end else if (mode_auto) begin
            pwm_running <= 1'b0;
          end else if (!pwm_running) begin
            pwm_start_ms <= now;
            pwm_running  <= 1'b1;
          end
        end
        sbc_pkg::ST_AUTO: begin
          if (faulted && !regs.fault_inhibit) begin
            valve_stage <= sbc_pkg::STAGE_OFF;
          end else begin
            valve_stage <= auto_stage;
          end
        end
        sbc_pkg::ST_APPLY: begin
          valve_stage <= (prod_into <= prod_duty) ? pwm_level : sbc_pkg::STAGE_OFF;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_stage   <= valve_stage;
      out_status  <= status;
      out_faulted <= faulted;
      out_err     <= err;
    end
  end

  assign tick.ready               = in_ready;
  assign result.valid             = out_valid;
  assign result.valve_low_closed  = out_stage[0];
  assign result.valve_high_closed = out_stage[1];
  assign result.burner_status     = out_status;
  assign result.faulted           = out_faulted;
  assign result.control_error     = out_err;

`ifndef NO_ASSERTIONS
  // An accepted tick always moves the sequencer into evaluation.
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (tick.valid && tick.ready) |=> (state == sbc_pkg::ST_EVAL))
    else $error("accepted tick did not start evaluation");

  // The modulo unit finishes only while the sequencer waits for it.
  a_div_done_mod: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == sbc_pkg::ST_MOD))
    else $error("modulo result arrived outside the wait state");

  // A PWM session ends only on an auto tick.
  a_session_end: assert property (@(posedge clk) disable iff (rst)
    ($fell(pwm_running) && !$past(rst)) |->
      ($past(state) == sbc_pkg::ST_EVAL && $past(mode_auto)))
    else $error("PWM session ended outside auto mode");

  // Off mode always reports both valves closed.
  a_off_closed: assert property (@(posedge clk) disable iff (rst)
    (out_load && mode_off) |=> (result.valve_low_closed && result.valve_high_closed))
    else $error("valve open in off mode");
`endif

endmodule

// File: tb/staged_burner_controller_tb.sv
// Self-checking testbench for the staged burner controller with its own predictor.
`timescale 1ns / 100ps

module staged_burner_controller_tb;
  import sbc_pkg::*;

  // Run control.
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_CYCLES     = 500;
  localparam int DRAIN_CYCLES    = 60;
  localparam int RAND_PHASES     = 16;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int REPORT_LIMIT    = 10;
  localparam int PERIOD_MAX      = 600000;

  // The two unused drive mode codes, which must behave as off.
  localparam logic [MODE_BITS-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [TEMP_BITS-1:0] feedback;
    logic                        probe_fault;
    logic                        pilot_lit;
    logic signed [TEMP_BITS-1:0] target;
    logic [TIME_BITS-1:0]        now_ms;
  } tick_t;

  typedef struct packed {
    logic                        low_closed;
    logic                        high_closed;
    logic [1:0]                  status;
    logic                        faulted;
    logic signed [TEMP_BITS-1:0] error;
  } burner_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sbc_cfg_if cfg_if ();
  sbc_in_if  tick_if ();
  sbc_out_if result_if ();

  staged_burner_controller u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .tick   (tick_if),
    .result (result_if)
  );

  // Predictor copy of the registers and the controller state.
  cfg_t                 shadow_cfg;
  logic [1:0]           shadow_stage;
  logic [TIME_BITS-1:0] shadow_pwm_start;
  bit                   shadow_pwm_running;

  burner_outcome_t pending_outcomes[$];
  int              fail_count = 0;
  int              idle_cycles = 0;
  bit              quiet = 1'b0;
  int              hold_seq = 0;
  int              hold_seen = 0;
  int              hold_left = 0;
  int              stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic cfg_t default_config();
    cfg_t c;
    c.drive_mode    = MODE_OFF;
    c.fault_inhibit = 1'b0;
    c.pwm_period_ms = 1000;
    c.pwm_duty_pct  = 0;
    c.high_offset   = 160;
    c.medium_offset = 80;
    c.low_offset    = 0;
    c.hysteresis    = 16;
    return c;
  endfunction

  function automatic tick_t make_tick(int feedback, bit probe_fault, bit pilot_lit, int target,
                                      logic [TIME_BITS-1:0] now_ms);
    tick_t t;
    t.feedback    = TEMP_BITS'(feedback);
    t.probe_fault = probe_fault;
    t.pilot_lit   = pilot_lit;
    t.target      = TEMP_BITS'(target);
    t.now_ms      = now_ms;
    return t;
  endfunction

  // Works out the outcome of one tick and advances the predictor state.
  function automatic burner_outcome_t compute_burner_outcome(tick_t t);
    burner_outcome_t r;
    logic [MODE_BITS-1:0] mode;
    bit                   is_off;
    int                   err, hi, med, lo, hy;
    logic [TIME_BITS-1:0] elapsed;
    longint unsigned      period, into;
    mode     = shadow_cfg.drive_mode;
    is_off   = (mode == MODE_OFF) || (mode > MODE_PWM_IDLE);
    r.status = STATUS_PILOT_LIT;
    r.faulted = 1'b0;

    // Control error, or the fixed fault value when the probe is bad.
    if (t.probe_fault) begin
      r.status = STATUS_FEEDBACK_FLT;
      err = int'(PROBE_FAULT_ERR);
      if (mode == MODE_AUTO) r.faulted = 1'b1;
    end else begin
      err = int'($signed(t.target)) - int'($signed(t.feedback));
      if (err > 32767) err = 32767;
      if (err < -32768) err = -32768;
    end

    // Pilot judgement; off mode reports the plain pilot state.
    if (is_off) begin
      r.status = t.pilot_lit ? STATUS_PILOT_LIT : STATUS_PILOT_OFF;
      shadow_stage = STAGE_OFF;
    end else if (!t.pilot_lit) begin
      r.status = STATUS_PILOT_FLT;
      if (!shadow_cfg.fault_inhibit) r.faulted = 1'b1;
    end

    if (mode == MODE_AUTO) begin
      hi  = int'($signed(shadow_cfg.high_offset));
      med = int'($signed(shadow_cfg.medium_offset));
      lo  = int'($signed(shadow_cfg.low_offset));
      hy  = int'($unsigned(shadow_cfg.hysteresis));
      if (r.faulted && !shadow_cfg.fault_inhibit) begin
        shadow_stage = STAGE_OFF;
      end else begin
        // Step down at a threshold, step up only past threshold plus hysteresis.
        case (shadow_stage)
          STAGE_HIGH: begin
            if (!(err > hi)) shadow_stage = STAGE_MEDIUM;
          end
          STAGE_MEDIUM: begin
            if (err > hi + hy) shadow_stage = STAGE_HIGH;
            else if (!(err > med)) shadow_stage = STAGE_LOW;
          end
          STAGE_LOW: begin
            if (err > med + hy) shadow_stage = STAGE_MEDIUM;
            else if (!(err > lo)) shadow_stage = STAGE_OFF;
          end
          default: begin
            if (err > lo + hy) shadow_stage = STAGE_LOW;
          end
        endcase
      end
      shadow_pwm_running = 1'b0;
    end else if (!is_off) begin
      // PWM: the session start is latched on its first tick.
      if (!shadow_pwm_running) begin
        shadow_pwm_start   = t.now_ms;
        shadow_pwm_running = 1'b1;
      end
      period  = (shadow_cfg.pwm_period_ms == 0) ? 1 : shadow_cfg.pwm_period_ms;
      elapsed = t.now_ms - shadow_pwm_start;
      into    = elapsed % period;
      if (100 * into <= shadow_cfg.pwm_duty_pct * period) begin
        case (mode)
          MODE_PWM_LOW:  shadow_stage = STAGE_LOW;
          MODE_PWM_MED:  shadow_stage = STAGE_MEDIUM;
          MODE_PWM_HIGH: shadow_stage = STAGE_HIGH;
          default:       shadow_stage = STAGE_OFF;
        endcase
      end else begin
        shadow_stage = STAGE_OFF;
      end
    end

    r.low_closed  = shadow_stage[0];
    r.high_closed = shadow_stage[1];
    r.error       = TEMP_BITS'(err);
    return r;
  endfunction

  // Offers one tick, waits for it to be taken and records its outcome.
  task automatic send_tick(tick_t t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    tick_if.valid         <= 1'b1;
    tick_if.feedback_temp <= t.feedback;
    tick_if.probe_fault   <= t.probe_fault;
    tick_if.pilot_lit     <= t.pilot_lit;
    tick_if.target_temp   <= t.target;
    tick_if.now_ms        <= t.now_ms;
    do @(posedge clk); while (!tick_if.ready);
    pending_outcomes.push_back(compute_burner_outcome(t));
  endtask

  // Waits for the block to drain, then writes every register.
  task automatic load_config(cfg_t c);
    int                       i;
    reg_index_t               idx;
    logic [CFG_DATA_BITS-1:0] data;
    tick_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    for (i = 0; i < 8; i++) begin
      idx  = reg_index_t'(i);
      data = '0;
      case (idx)
        REG_DRIVE_MODE:    data[MODE_BITS-1:0] = c.drive_mode;
        REG_FAULT_INHIBIT: data[0] = c.fault_inhibit;
        REG_PWM_PERIOD:    data[PERIOD_BITS-1:0] = c.pwm_period_ms;
        REG_PWM_DUTY:      data[DUTY_BITS-1:0] = c.pwm_duty_pct;
        REG_HIGH_OFFSET:   data[OFFSET_BITS-1:0] = c.high_offset;
        REG_MEDIUM_OFFSET: data[OFFSET_BITS-1:0] = c.medium_offset;
        REG_LOW_OFFSET:    data[OFFSET_BITS-1:0] = c.low_offset;
        default:           data[HYST_BITS-1:0] = c.hysteresis;
      endcase
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= data;
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    shadow_cfg = c;
  endtask

  // Off mode and the two unused mode codes, with saturation at both ends.
  task automatic test_off_modes();
    cfg_t c;
    c = default_config();
    load_config(c);
    send_tick(make_tick(0, 1'b0, 1'b1, 0, 0));
    send_tick(make_tick(-32768, 1'b0, 1'b0, 32767, 32'hFFFF_FFFF));
    send_tick(make_tick(32767, 1'b1, 1'b1, -32768, 3));
    c.drive_mode = MODE_SPARE_A;
    load_config(c);
    send_tick(make_tick(32767, 1'b0, 1'b0, -32768, 5));
    c.drive_mode = MODE_SPARE_B;
    load_config(c);
    send_tick(make_tick(-1, 1'b1, 1'b0, 100, 6));
  endtask

  // Auto mode: walk the stages up and down, then the fault paths.
  task automatic test_auto_stages();
    cfg_t c;
    c = default_config();
    c.drive_mode = MODE_AUTO;
    load_config(c);
    // Errors of 17, 97, 177 step up; 160, 80, 0 step back down.
    send_tick(make_tick(1000 - 17, 1'b0, 1'b1, 1000, 10));
    send_tick(make_tick(1000 - 97, 1'b0, 1'b1, 1000, 11));
    send_tick(make_tick(1000 - 177, 1'b0, 1'b1, 1000, 12));
    send_tick(make_tick(1000 - 160, 1'b0, 1'b1, 1000, 13));
    send_tick(make_tick(1000 - 80, 1'b0, 1'b1, 1000, 14));
    send_tick(make_tick(1000, 1'b0, 1'b1, 1000, 15));
    send_tick(make_tick(1000 - 17, 1'b0, 1'b1, 1000, 16));
    send_tick(make_tick(1000, 1'b1, 1'b1, 1000, 17));
    send_tick(make_tick(1000 - 500, 1'b0, 1'b0, 1000, 18));
    // With faults inhibited, control keeps running through an unlit pilot.
    c.fault_inhibit = 1'b1;
    load_config(c);
    send_tick(make_tick(1000 - 17, 1'b0, 1'b0, 1000, 19));
    send_tick(make_tick(1000, 1'b1, 1'b1, 1000, 20));
  endtask

  // PWM sessions, zero period, full duty, fault in PWM and session end.
  task automatic test_pwm_cases();
    cfg_t c;
    c = default_config();
    c.drive_mode    = MODE_PWM_LOW;
    c.pwm_period_ms = 10;
    c.pwm_duty_pct  = 50;
    load_config(c);
    send_tick(make_tick(0, 1'b0, 1'b1, 0, 1000));
    send_tick(make_tick(0, 1'b0, 1'b1, 0, 1005));
    send_tick(make_tick(0, 1'b0, 1'b1, 0, 1006));
    // Off keeps the session alive.
    c.drive_mode = MODE_OFF;
    load_config(c);
    send_tick(make_tick(0, 1'b0, 1'b1, 0, 2000));
    c.drive_mode    = MODE_PWM_HIGH;
    c.pwm_period_ms = 0;
    c.pwm_duty_pct  = 0;
    load_config(c);
    send_tick(make_tick(0, 1'b0, 1'b1, 0, 7));
    send_tick(make_tick(0, 1'b0, 1'b0, 0, 9));
    c.drive_mode    = MODE_PWM_MED;
    c.pwm_period_ms = PERIOD_MAX;
    c.pwm_duty_pct  = 127;
    load_config(c);
    send_tick(make_tick(5, 1'b0, 1'b1, 5, 32'hFFFF_FFF0));
    c.drive_mode = MODE_PWM_IDLE;
    load_config(c);
    send_tick(make_tick(5, 1'b0, 1'b1, 5, 32'h0000_0004));
    // Auto ends the session, so the next PWM tick starts a new one.
    c.drive_mode = MODE_AUTO;
    load_config(c);
    send_tick(make_tick(0, 1'b0, 1'b1, 0, 40));
    c.drive_mode    = MODE_PWM_LOW;
    c.pwm_period_ms = 10;
    load_config(c);
    send_tick(make_tick(0, 1'b0, 1'b1, 0, 55));
    send_tick(make_tick(0, 1'b0, 1'b1, 0, 56));
  endtask

  // The result side holds off for a long stretch while ticks keep coming.
  task automatic test_backpressure();
    cfg_t              c;
    int                n;
    logic [TIME_BITS-1:0] clock_ms;
    c = default_config();
    c.drive_mode    = MODE_PWM_MED;
    c.pwm_period_ms = 100;
    c.pwm_duty_pct  = 40;
    load_config(c);
    clock_ms = $urandom();
    hold_seq <= hold_seq + 1;
    for (n = 0; n < 40; n++) begin
      clock_ms = clock_ms + $urandom_range(1, 30);
      send_tick(make_tick(int'($urandom_range(0, 2000)), 1'b0, 1'b1, 1000, clock_ms));
    end
  endtask

  // Random phases, each with its own settings; ticks mostly aim at the thresholds.
  task automatic test_random_ticks();
    cfg_t                 c;
    tick_t                t;
    int                   phase, n, e, mag, base, lo, med, hi, hy;
    int unsigned          period, step_max;
    logic [TIME_BITS-1:0] clock_ms;
    clock_ms = $urandom();
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      c = default_config();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: c.drive_mode = MODE_AUTO;
        4:          c.drive_mode = MODE_OFF;
        5:          c.drive_mode = MODE_PWM_LOW;
        6:          c.drive_mode = MODE_PWM_MED;
        7:          c.drive_mode = MODE_PWM_HIGH;
        8:          c.drive_mode = MODE_PWM_IDLE;
        default:    c.drive_mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
      endcase
      c.fault_inhibit = $urandom_range(0, 1);
      case ($urandom_range(0, 7))
        0:       c.pwm_period_ms = 0;
        1:       c.pwm_period_ms = PERIOD_MAX;
        2, 3:    c.pwm_period_ms = $urandom_range(1, PERIOD_MAX);
        default: c.pwm_period_ms = $urandom_range(1, 200);
      endcase
      c.pwm_duty_pct = ($urandom_range(0, 4) == 0) ? $urandom_range(101, 127)
                                                   : $urandom_range(0, 100);
      if ($urandom_range(0, 3) != 0) begin
        // Ordered thresholds close together so that every stage is reached.
        base            = int'($urandom_range(0, 800)) - 400;
        c.low_offset    = OFFSET_BITS'(base);
        c.medium_offset = OFFSET_BITS'(base + int'($urandom_range(0, 300)));
        c.high_offset   = OFFSET_BITS'(int'($signed(c.medium_offset)) +
                                       int'($urandom_range(0, 300)));
        c.hysteresis    = $urandom_range(0, 100);
      end else begin
        c.low_offset    = OFFSET_BITS'($urandom());
        c.medium_offset = OFFSET_BITS'($urandom());
        c.high_offset   = OFFSET_BITS'($urandom());
        c.hysteresis    = HYST_BITS'($urandom());
      end
      // The first two phases take the register extremes.
      if (phase == 0) begin
        c.drive_mode    = MODE_AUTO;
        c.fault_inhibit = 1'b0;
        c.high_offset   = 32767;
        c.medium_offset = 32767;
        c.low_offset    = 32767;
        c.hysteresis    = 32767;
        c.pwm_period_ms = PERIOD_MAX;
        c.pwm_duty_pct  = 100;
      end else if (phase == 1) begin
        c.drive_mode    = MODE_AUTO;
        c.fault_inhibit = 1'b1;
        c.high_offset   = -32768;
        c.medium_offset = -32768;
        c.low_offset    = -32768;
        c.hysteresis    = 0;
        c.pwm_period_ms = 1;
      end
      load_config(c);
      quiet <= (phase == RAND_PHASES - 1);

      lo       = int'($signed(c.low_offset));
      med      = int'($signed(c.medium_offset));
      hi       = int'($signed(c.high_offset));
      hy       = int'($unsigned(c.hysteresis));
      period   = (c.pwm_period_ms == 0) ? 1 : c.pwm_period_ms;
      step_max = period / 4 + 1;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 70) begin
          // Well-formed tick with an error near one of the thresholds.
          case ($urandom_range(0, 5))
            0:       e = lo;
            1:       e = med;
            2:       e = hi;
            3:       e = lo + hy;
            4:       e = med + hy;
            default: e = hi + hy;
          endcase
          if ($urandom_range(0, 3) == 0) e = e + int'($urandom_range(0, 1000)) - 500;
          else e = e + int'($urandom_range(0, 6)) - 3;
          if (e > 32767) e = 32767;
          if (e < -32768) e = -32768;
          mag  = (e < 0) ? -e : e;
          base = -32768 + int'($urandom_range(0, 65535 - mag));
          if (e < 0) base = base + mag;
          clock_ms      = clock_ms + $urandom_range(1, step_max);
          t             = make_tick(base, $urandom_range(0, 49) == 0,
                                    $urandom_range(0, 19) != 0, base + e, clock_ms);
        end else begin
          // Noise: any field values, often at the extremes.
          t.feedback    = TEMP_BITS'($urandom());
          t.target      = TEMP_BITS'($urandom());
          case ($urandom_range(0, 5))
            0: t.feedback = -32768;
            1: t.feedback = 32767;
            2: t.target   = -32768;
            3: t.target   = 32767;
            default: ;
          endcase
          t.probe_fault = $urandom_range(0, 1);
          t.pilot_lit   = $urandom_range(0, 1);
          if ($urandom_range(0, 4) == 0) clock_ms = $urandom();
          else clock_ms = clock_ms + $urandom_range(0, step_max);
          t.now_ms      = clock_ms;
        end
        send_tick(t);
      end
    end
  endtask

  // Result side: random stalls, one long hold when asked, none in the quiet part.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen       <= hold_seq;
      hold_left       <= HOLD_CYCLES - 1;
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      result_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left      <= $urandom_range(1, 14) - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Compare each result item with the oldest outcome still waiting.
  always @(posedge clk) begin
    burner_outcome_t got, want;
    if (!rst && result_if.valid && result_if.ready) begin
      got.low_closed  = result_if.valve_low_closed;
      got.high_closed = result_if.valve_high_closed;
      got.status      = result_if.burner_status;
      got.faulted     = result_if.faulted;
      got.error       = result_if.control_error;
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("Unexpected result item: low=%0b high=%0b status=%0d faulted=%0b error=%0d",
                   got.low_closed, got.high_closed, got.status, got.faulted, got.error);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.low_closed !== want.low_closed || got.high_closed !== want.high_closed ||
            got.status !== want.status || got.faulted !== want.faulted ||
            got.error !== want.error) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display({"Result mismatch: expected low=%0b high=%0b status=%0d faulted=%0b ",
                      "error=%0d, got low=%0b high=%0b status=%0d faulted=%0b error=%0d"},
                     want.low_closed, want.high_closed, want.status, want.faulted, want.error,
                     got.low_closed, got.high_closed, got.status, got.faulted, got.error);
        end
      end
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (tick_if.valid && tick_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tick_if.valid         = 1'b0;
    tick_if.feedback_temp = '0;
    tick_if.probe_fault   = 1'b0;
    tick_if.pilot_lit     = 1'b0;
    tick_if.target_temp   = '0;
    tick_if.now_ms        = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_DRIVE_MODE;
    cfg_if.data           = '0;
    result_if.ready       = 1'b0;
    shadow_cfg            = default_config();
    shadow_stage          = STAGE_OFF;
    shadow_pwm_start      = '0;
    shadow_pwm_running    = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_off_modes();
    test_auto_stages();
    test_pwm_cases();
    test_backpressure();
    test_random_ticks();

    // Drain, then let the block settle before the verdict.
    tick_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_outcomes.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
